// ----- sv/gbs_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gbs_pkg
// Shared types and constants for the greedy box suppression block.
// ----------------------------------------------------------------------------
package gbs_pkg;

   // Field widths
   localparam int COORD_W = 16;
   localparam int EDGE_W  = 18;
   localparam int LABEL_W = 7;
   localparam int AREA_W  = 32;
   localparam int THR_W   = 16;
   localparam int INDEX_W = 16;

   // Configuration port
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 16;
   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_AGNOSTIC  = 1'b1;

   // Reset values and defaults
   localparam logic [THR_W-1:0] THR_RESET = 16'd29491;
   localparam int MAX_KEPT_DEF = 64;

   // Controller states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SETUP,
      ST_SCAN,
      ST_COMMIT
   } gbs_state_type;

   // Controller to datapath
   typedef struct packed {
      logic capture;  // latch incoming item
      logic setup;    // form edges and area
      logic scan;     // issue one kept-box read
      logic commit;   // write result, store box
   } gbs_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic scan_done;  // every kept box issued
      logic pipe_busy;  // compare pipeline holds an entry
      logic out_free;   // result register can take an item
   } gbs_sts_type;

   // One kept box
   typedef struct packed {
      logic [COORD_W-1:0] left;
      logic [COORD_W-1:0] top;
      logic [EDGE_W-1:0]  right;
      logic [EDGE_W-1:0]  bottom;
      logic [LABEL_W-1:0] label;
      logic [AREA_W-1:0]  area;
   } gbs_entry_type;

endpackage
`default_nettype wire

// ----- sv/gbs_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gbs_ctrl
// Sequencer: accepts an item, runs the scan over kept boxes, commits result.
// ----------------------------------------------------------------------------
module gbs_ctrl (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_valid,
   output logic                 req_ready,
   input  gbs_pkg::gbs_sts_type sts,
   output gbs_pkg::gbs_cmd_type cmd
);
   import gbs_pkg::*;

   gbs_state_type state_ff;
   gbs_state_type state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_SETUP;
         end
         ST_SETUP: begin
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (sts.scan_done) state_in = ST_COMMIT;
         end
         ST_COMMIT: begin
            if (!sts.pipe_busy && sts.out_free) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Outputs
   always_comb begin
      req_ready   = 1'b0;
      cmd         = '0;
      case (state_ff)
         ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
         end
         ST_SETUP: begin
            cmd.setup = 1'b1;
         end
         ST_SCAN: begin
            cmd.scan = !sts.scan_done;
         end
         ST_COMMIT: begin
            cmd.commit = !sts.pipe_busy && sts.out_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

endmodule
`default_nettype wire

// ----- sv/gbs_dpath.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gbs_dpath
// Kept-box memory, config registers and the pipelined overlap compare.
// ----------------------------------------------------------------------------
module gbs_dpath #(
   parameter int MAX_KEPT = gbs_pkg::MAX_KEPT_DEF
) (
   input  wire                                 clock,
   input  wire                                 reset,
   input  gbs_pkg::gbs_cmd_type                cmd,
   output gbs_pkg::gbs_sts_type                sts,
   input  wire                                 csr_wr_en,
   input  wire  [gbs_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire  [gbs_pkg::CSR_DATA_W-1:0]      csr_wr_data,
   input  wire                                 req_start_of_set,
   input  wire  signed [gbs_pkg::COORD_W-1:0]  req_box_left,
   input  wire  signed [gbs_pkg::COORD_W-1:0]  req_box_top,
   input  wire  [gbs_pkg::COORD_W-1:0]         req_box_width,
   input  wire  [gbs_pkg::COORD_W-1:0]         req_box_height,
   input  wire  [gbs_pkg::LABEL_W-1:0]         req_class_label,
   output logic                                rsp_valid,
   input  wire                                 rsp_ready,
   output logic                                rsp_keep,
   output logic [gbs_pkg::INDEX_W-1:0]         rsp_item_index,
   output logic                                rsp_store_full
);
   import gbs_pkg::*;

   localparam int IDX_W = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
   localparam int CNT_W = $clog2(MAX_KEPT + 1);
   localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_KEPT);
   localparam logic [INDEX_W-1:0] INDEX_MAX = '1;
   localparam int SUM_W  = AREA_W + 1;
   localparam int PROD_W = THR_W + SUM_W;

   // Config registers
   logic [THR_W-1:0] thr_ff;
   logic             agn_ff;

   // Control state
   logic [CNT_W-1:0]   count_ff,   count_in;
   logic [INDEX_W-1:0] box_cnt_ff, box_cnt_in;
   logic [CNT_W-1:0]   scan_ff,    scan_in;
   logic               suppress_ff, suppress_in;
   logic               vrd_ff, va_ff, vb_ff, vc_ff, vd_ff;
   logic               va_in;
   logic               rsp_valid_ff, rsp_valid_in;

   // Item payload
   logic signed [COORD_W-1:0] left_ff, top_ff;
   logic [COORD_W-1:0]        width_ff, height_ff;
   logic [LABEL_W-1:0]        label_ff;
   logic signed [EDGE_W-1:0]  right_ff, bottom_ff;
   logic [AREA_W-1:0]         area_ff;
   logic [INDEX_W-1:0]        index_ff;

   // Memory and pipeline payload
   gbs_entry_type      mem [MAX_KEPT];
   gbs_entry_type      rd_ff;
   gbs_entry_type      wr_entry;
   logic [COORD_W-1:0] iw_ff, ih_ff, iw_in, ih_in;
   logic [AREA_W-1:0]  karea_ff;
   logic [AREA_W-1:0]  inter_b_ff, inter_c_ff, inter_d_ff;
   logic [SUM_W-1:0]   sum_ff, uni_ff;
   logic [PROD_W-1:0]  prod_ff;

   logic                      rsp_keep_ff, rsp_full_ff;
   logic [INDEX_W-1:0]        rsp_index_ff;
   logic                      keep_now, full_now;
   logic [INDEX_W-1:0]        cnt_base;

   // Stage A intermediates
   logic signed [EDGE_W-1:0]  k_right, k_bottom, min_x, min_y;
   logic signed [COORD_W-1:0] k_left, k_top, max_x, max_y;
   logic signed [EDGE_W:0]    iw_full, ih_full;
   logic                      overlap;
   logic                      hit;

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= THR_RESET;
         agn_ff <= 1'b0;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_THRESHOLD: thr_ff <= csr_wr_data[THR_W-1:0];
            CSR_AGNOSTIC:  agn_ff <= csr_wr_data[0];
            default:       thr_ff <= thr_ff;
         endcase
      end
   end

   // Result of the current item
   assign keep_now = !suppress_ff;
   assign full_now = keep_now && (count_ff == MAX_CNT);
   assign cnt_base = req_start_of_set ? '0 : box_cnt_ff;

   // Control next values
   always_comb begin
      count_in     = count_ff;
      box_cnt_in   = box_cnt_ff;
      scan_in      = scan_ff;
      suppress_in  = suppress_ff || hit;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (cmd.capture) begin
         // start marker empties the list and restarts numbering
         if (req_start_of_set) count_in = '0;
         box_cnt_in  = (cnt_base == INDEX_MAX) ? cnt_base : cnt_base + 1'b1;
         scan_in     = '0;
         suppress_in = 1'b0;
      end
      if (cmd.scan) scan_in = scan_ff + 1'b1;
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
         if (keep_now && !full_now) count_in = count_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         box_cnt_ff   <= '0;
         scan_ff      <= '0;
         suppress_ff  <= 1'b0;
         vrd_ff       <= 1'b0;
         va_ff        <= 1'b0;
         vb_ff        <= 1'b0;
         vc_ff        <= 1'b0;
         vd_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         box_cnt_ff   <= box_cnt_in;
         scan_ff      <= scan_in;
         suppress_ff  <= suppress_in;
         vrd_ff       <= cmd.scan;
         va_ff        <= va_in;
         vb_ff        <= va_ff;
         vc_ff        <= vb_ff;
         vd_ff        <= vc_ff;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Item capture and setup
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         left_ff   <= req_box_left;
         top_ff    <= req_box_top;
         width_ff  <= req_box_width;
         height_ff <= req_box_height;
         label_ff  <= req_class_label;
         index_ff  <= cnt_base;
      end
      if (cmd.setup) begin
         right_ff  <= EDGE_W'(left_ff) + $signed({2'b00, width_ff});
         bottom_ff <= EDGE_W'(top_ff) + $signed({2'b00, height_ff});
         area_ff   <= {16'b0, width_ff} * {16'b0, height_ff};
      end
   end

   // Kept-box memory: one write at commit, one registered read per scan cycle
   always_comb begin
      wr_entry.left   = left_ff;
      wr_entry.top    = top_ff;
      wr_entry.right  = right_ff;
      wr_entry.bottom = bottom_ff;
      wr_entry.label  = label_ff;
      wr_entry.area   = area_ff;
   end

   always_ff @(posedge clock) begin
      if (cmd.commit && keep_now && !full_now) begin
         mem[count_ff[IDX_W-1:0]] <= wr_entry;
      end
      rd_ff <= mem[scan_ff[IDX_W-1:0]];
   end

   // Stage A: intersection extents, label filter
   always_comb begin
      k_left   = $signed(rd_ff.left);
      k_top    = $signed(rd_ff.top);
      k_right  = $signed(rd_ff.right);
      k_bottom = $signed(rd_ff.bottom);
      min_x    = (right_ff < k_right) ? right_ff : k_right;
      min_y    = (bottom_ff < k_bottom) ? bottom_ff : k_bottom;
      max_x    = (left_ff > k_left) ? left_ff : k_left;
      max_y    = (top_ff > k_top) ? top_ff : k_top;
      iw_full  = $signed({min_x[EDGE_W-1], min_x}) - (EDGE_W + 1)'(max_x);
      ih_full  = $signed({min_y[EDGE_W-1], min_y}) - (EDGE_W + 1)'(max_y);
      // disjoint or touching boxes give no intersection
      overlap  = !iw_full[EDGE_W] && (iw_full != '0) &&
                 !ih_full[EDGE_W] && (ih_full != '0);
      iw_in    = overlap ? iw_full[COORD_W-1:0] : '0;
      ih_in    = overlap ? ih_full[COORD_W-1:0] : '0;
      va_in    = vrd_ff && (agn_ff || (rd_ff.label == label_ff));
   end

   // Stages A to D payload
   always_ff @(posedge clock) begin
      iw_ff      <= iw_in;
      ih_ff      <= ih_in;
      karea_ff   <= rd_ff.area;
      // B: intersection area, area sum
      inter_b_ff <= {16'b0, iw_ff} * {16'b0, ih_ff};
      sum_ff     <= {1'b0, area_ff} + {1'b0, karea_ff};
      // C: union
      uni_ff     <= sum_ff - {1'b0, inter_b_ff};
      inter_c_ff <= inter_b_ff;
      // D: threshold times union
      prod_ff    <= {{SUM_W{1'b0}}, thr_ff} * {{THR_W{1'b0}}, uni_ff};
      inter_d_ff <= inter_c_ff;
   end

   // Suppress when intersection / union exceeds the threshold
   assign hit = vd_ff && ({1'b0, inter_d_ff, 16'b0} > prod_ff);

   // Result register
   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_keep_ff  <= keep_now;
         rsp_full_ff  <= full_now;
         rsp_index_ff <= index_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_keep       = rsp_keep_ff;
   assign rsp_store_full = rsp_full_ff;
   assign rsp_item_index = rsp_index_ff;

   // Status
   assign sts.scan_done = (scan_ff == count_ff);
   assign sts.pipe_busy = vrd_ff || va_ff || vb_ff || vc_ff || vd_ff;
   assign sts.out_free  = !rsp_valid_ff || rsp_ready;

endmodule
`default_nettype wire

// ----- sv/greedy_box_suppression.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// greedy_box_suppression
// Greedy IoU suppression over boxes arriving in falling score order.
// ----------------------------------------------------------------------------
// One item is processed at a time. From one accept to the next, the block
// takes the item, forms its edges and area, reads the kept boxes of the set
// (at most MAX_KEPT) out of memory one per cycle, lets the last compare leave
// the pipeline and commits the result; with an empty list nothing is read.
// The drain is shorter when the label filter skips the tail of the list.
// A finished result sits in an output register, so the next item is taken
// while it waits; a result still unread at commit time holds the block until
// it is taken. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module greedy_box_suppression #(
   parameter int MAX_KEPT = gbs_pkg::MAX_KEPT_DEF
) (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 csr_wr_en,
   input  wire  [gbs_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire  [gbs_pkg::CSR_DATA_W-1:0]      csr_wr_data,
   input  wire                                 req_valid,
   output logic                                req_ready,
   input  wire                                 req_start_of_set,
   input  wire  signed [gbs_pkg::COORD_W-1:0]  req_box_left,
   input  wire  signed [gbs_pkg::COORD_W-1:0]  req_box_top,
   input  wire  [gbs_pkg::COORD_W-1:0]         req_box_width,
   input  wire  [gbs_pkg::COORD_W-1:0]         req_box_height,
   input  wire  [gbs_pkg::LABEL_W-1:0]         req_class_label,
   output logic                                rsp_valid,
   input  wire                                 rsp_ready,
   output logic                                rsp_keep,
   output logic [gbs_pkg::INDEX_W-1:0]         rsp_item_index,
   output logic                                rsp_store_full
);
   import gbs_pkg::*;

   gbs_cmd_type cmd;
   gbs_sts_type sts;

   gbs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   gbs_dpath #(
      .MAX_KEPT (MAX_KEPT)
   ) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wr_data      (csr_wr_data),
      .req_start_of_set (req_start_of_set),
      .req_box_left     (req_box_left),
      .req_box_top      (req_box_top),
      .req_box_width    (req_box_width),
      .req_box_height   (req_box_height),
      .req_class_label  (req_class_label),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_keep         (rsp_keep),
      .rsp_item_index   (rsp_item_index),
      .rsp_store_full   (rsp_store_full)
   );

   // One item in flight: no second accept right after the first
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("second item accepted while one is in flight");

   // A full store is only reported for a kept box
   a_full_kept: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_store_full) |-> rsp_keep)
      else $error("store_full without keep");

   // Results are committed only after the compare pipeline has drained
   a_commit_drained: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> (!sts.pipe_busy && sts.scan_done))
      else $error("commit with compares outstanding");

   // No two datapath commands are ever active together
   a_cmd_excl: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.capture, cmd.setup, cmd.scan, cmd.commit}))
      else $error("conflicting datapath commands");

endmodule
`default_nettype wire
